// ----- src/mme_pkg.sv -----
// Package for the matrix multiply engine: payload types, codes and fixed widths.
package mme_pkg;

	localparam int DIM_W      = 7;
	localparam int ROW_W      = 6;
	localparam int IDX_IN_W   = 12;
	localparam int VAL_W      = 32;
	localparam int SUM_W      = 64;
	localparam int STATUS_W   = 2;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	// Wide enough for any computed store index and for a depth of 65536
	localparam int IDX_W      = 17;

	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_A      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_TRANSPOSED = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [IDX_IN_W-1:0]     elem_index;
		logic signed [VAL_W-1:0] elem_value;
		logic [ROW_W-1:0]        query_row;
		logic [ROW_W-1:0]        query_col;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_value;
		logic [ROW_W-1:0]        out_row;
		logic [ROW_W-1:0]        out_col;
		logic [STATUS_W-1:0]     status;
	} out_item_t;

	// Control handed from the read sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic a_zero;
		logic b_zero;
	} mac_ctrl_t;

endpackage

// ----- src/mme_mac.sv -----
// Multiply-accumulate unit: registered product, then saturating Q32.32 sum.
module mme_mac #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mme_pkg::mac_ctrl_t                 ctrl,
	input  logic [ELEM_WIDTH-1:0]              a_data,
	input  logic [ELEM_WIDTH-1:0]              b_data,
	output logic signed [mme_pkg::SUM_W-1:0]   acc,
	output logic                               busy
);

	logic signed [2*ELEM_WIDTH-1:0]     prod_w;
	logic signed [mme_pkg::SUM_W-1:0]   product_s2;
	logic                               vld_s2;
	logic signed [mme_pkg::SUM_W-1:0]   acc_q;
	logic signed [mme_pkg::SUM_W-1:0]   sum_w;
	logic                               ovf_w;

	assign prod_w = $signed(a_data) * $signed(b_data);

	// Product stage; an index beyond the store counts as zero
	always_ff @(posedge clk) begin
		if (ctrl.a_zero || ctrl.b_zero) begin
			product_s2 <= '0;
		end else begin
			product_s2 <= mme_pkg::SUM_W'(prod_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctrl.valid;
		end
	end

	assign sum_w = acc_q + product_s2;
	assign ovf_w = (acc_q[mme_pkg::SUM_W-1] == product_s2[mme_pkg::SUM_W-1])
		&& (sum_w[mme_pkg::SUM_W-1] != acc_q[mme_pkg::SUM_W-1]);

	// Accumulate stage: clamp to the 64-bit bounds after every addition
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			if (ovf_w) begin
				acc_q <= acc_q[mme_pkg::SUM_W-1]
					? {1'b1, {(mme_pkg::SUM_W-1){1'b0}}}
					: {1'b0, {(mme_pkg::SUM_W-1){1'b1}}};
			end else begin
				acc_q <= sum_w;
			end
		end
	end

	assign acc  = acc_q;
	assign busy = vld_s2;

endmodule

// ----- src/matrix_multiply_engine.sv -----
// Top level of the matrix multiply engine: element stores, query sequencer, result register.
//
// Usage: load A and B one element per input transfer (cmd load A / load B, flat
// row-major elem_index), then send query transfers naming a result row and column.
// Each query gives one output transfer with the saturated Q32.32 dot product and a
// status; loads and the unused command give none.
// Configuration registers (index 0..4: num_rows, inner_a, rows_b, num_cols,
// b_transposed) are written over the cfg channel, which is always ready; write them
// only while the block is idle.
// A load writes its element store at the input transfer. A query that runs steps
// through run, drain and done states, one multiply-accumulate per cycle through
// the single read port of each element store; an erroneous or empty query goes
// straight to done. in_stall stays high while a query is being worked on.
// The result register parts the two sides: a new item is taken while a result still
// waits; a finished query holds in its last step while out_stall keeps the register
// full. Reset sets control state, valid flags and config registers to defaults; data
// registers and element stores keep what they held; the stores need loading before use.
module matrix_multiply_engine #(
	parameter int MAX_DIM     = 64,
	parameter int STORE_DEPTH = 4096,
	parameter int ELEM_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mme_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mme_pkg::out_item_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mme_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW        = $clog2(STORE_DEPTH);
	localparam int DIM_RESET = (64 > MAX_DIM) ? MAX_DIM : 64;
	localparam logic [mme_pkg::IDX_W-1:0] DEPTH_L = mme_pkg::IDX_W'(STORE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	// Clamp a written dimension to MAX_DIM
	function automatic logic [mme_pkg::DIM_W-1:0] dim_sat(
		input logic [mme_pkg::CFG_DATA_W-1:0] v
	);
		logic [8:0] wide;
		wide = 9'(v);
		if (wide > 9'(MAX_DIM)) begin
			return mme_pkg::DIM_W'(MAX_DIM);
		end
		return mme_pkg::DIM_W'(v);
	endfunction

	logic [mme_pkg::DIM_W-1:0]   num_rows_q, inner_a_q, rows_b_q, num_cols_q;
	logic                        b_trans_q;

	logic [1:0]                  state_q;
	logic [mme_pkg::DIM_W-1:0]   k_q;
	logic [mme_pkg::IDX_W-1:0]   a_idx_q, b_idx_q, b_step_q;
	logic [mme_pkg::ROW_W-1:0]   row_q, col_q;
	logic [mme_pkg::STATUS_W-1:0] status_q;

	logic                        rd_vld_s1, a_zero_s1, b_zero_s1;
	logic [ELEM_WIDTH-1:0]       a_rd_s1, b_rd_s1;

	logic [ELEM_WIDTH-1:0]       a_mem [STORE_DEPTH];
	logic [ELEM_WIDTH-1:0]       b_mem [STORE_DEPTH];

	logic                        out_valid_q;
	mme_pkg::out_item_t          out_q;

	logic                        in_fire, load_ok, a_we, b_we, query_go, out_load;
	logic [mme_pkg::IDX_W-1:0]   load_idx;
	logic [mme_pkg::STATUS_W-1:0] q_status;
	logic                        q_run;
	mme_pkg::mac_ctrl_t          mac_ctrl;
	logic signed [mme_pkg::SUM_W-1:0] acc;
	logic                        mac_busy;

	// Configuration: always ready, indexes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= mme_pkg::DIM_W'(DIM_RESET);
			inner_a_q  <= mme_pkg::DIM_W'(DIM_RESET);
			rows_b_q   <= mme_pkg::DIM_W'(DIM_RESET);
			num_cols_q <= mme_pkg::DIM_W'(DIM_RESET);
			b_trans_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mme_pkg::REG_NUM_ROWS:     num_rows_q <= dim_sat(cfg_data);
				mme_pkg::REG_INNER_A:      inner_a_q  <= dim_sat(cfg_data);
				mme_pkg::REG_ROWS_B:       rows_b_q   <= dim_sat(cfg_data);
				mme_pkg::REG_NUM_COLS:     num_cols_q <= dim_sat(cfg_data);
				mme_pkg::REG_B_TRANSPOSED: b_trans_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input side: items are taken only between queries
	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;

	assign load_idx = mme_pkg::IDX_W'(in_data.elem_index);
	assign load_ok  = load_idx < DEPTH_L;
	assign a_we     = in_fire && (in_data.cmd == mme_pkg::CMD_LOAD_A) && load_ok;
	assign b_we     = in_fire && (in_data.cmd == mme_pkg::CMD_LOAD_B) && load_ok;
	assign query_go = in_fire && (in_data.cmd == mme_pkg::CMD_QUERY);

	// Decide the query's status at the transfer; mismatch outranks range
	always_comb begin
		priority if (inner_a_q != rows_b_q) begin
			q_status = mme_pkg::STATUS_MISMATCH;
		end else if ((mme_pkg::DIM_W'(in_data.query_row) >= num_rows_q)
			|| (mme_pkg::DIM_W'(in_data.query_col) >= num_cols_q)) begin
			q_status = mme_pkg::STATUS_RANGE;
		end else begin
			q_status = mme_pkg::STATUS_OK;
		end
	end
	assign q_run = (q_status == mme_pkg::STATUS_OK) && (inner_a_q != '0);

	// Element stores. Writes happen only in idle and read data is used only while a query
	// runs, so a write never meets a used read of the same entry in the same cycle.
	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[load_idx[AW-1:0]] <= in_data.elem_value[ELEM_WIDTH-1:0];
		end
		a_rd_s1 <= a_mem[a_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[load_idx[AW-1:0]] <= in_data.elem_value[ELEM_WIDTH-1:0];
		end
		b_rd_s1 <= b_mem[b_idx_q[AW-1:0]];
	end

	// Read issue: flag indexes beyond the store so they count as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_RUN);
		end
	end

	always_ff @(posedge clk) begin
		a_zero_s1 <= a_idx_q >= DEPTH_L;
		b_zero_s1 <= b_idx_q >= DEPTH_L;
	end

	// Sequencer: walk k over the inner dimension, one read pair per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						state_q <= q_run ? ST_RUN : ST_DONE;
					end
				end
				ST_RUN: begin
					if (k_q == inner_a_q - 1'b1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !mac_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Index registers: start at the row or column base, then step per k
	always_ff @(posedge clk) begin
		if (query_go) begin
			k_q      <= '0;
			row_q    <= in_data.query_row;
			col_q    <= in_data.query_col;
			status_q <= q_status;
			a_idx_q  <= mme_pkg::IDX_W'(in_data.query_row) * mme_pkg::IDX_W'(inner_a_q);
			if (b_trans_q) begin
				b_idx_q  <= mme_pkg::IDX_W'(in_data.query_col) * mme_pkg::IDX_W'(inner_a_q);
				b_step_q <= mme_pkg::IDX_W'(1);
			end else begin
				b_idx_q  <= mme_pkg::IDX_W'(in_data.query_col);
				b_step_q <= mme_pkg::IDX_W'(num_cols_q);
			end
		end else if (state_q == ST_RUN) begin
			k_q     <= k_q + 1'b1;
			a_idx_q <= a_idx_q + 1'b1;
			b_idx_q <= b_idx_q + b_step_q;
		end
	end

	assign mac_ctrl.clear  = query_go;
	assign mac_ctrl.valid  = rd_vld_s1;
	assign mac_ctrl.a_zero = a_zero_s1;
	assign mac_ctrl.b_zero = b_zero_s1;

	mme_mac #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.a_data (a_rd_s1),
		.b_data (b_rd_s1),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// Result register: fill when empty or being emptied in this cycle
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.sum_value <= (status_q == mme_pkg::STATUS_OK) ? acc : '0;
			out_q.out_row   <= row_q;
			out_q.out_col   <= col_q;
			out_q.status    <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
